/* rtl/core/lpb_pkg.sv */
// Shared types and constants for the layer pixel blend block.
// Used by lpb_channel, layer_pixel_blend and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lpb_pkg;

   localparam int PIX_W    = 8;
   localparam int WEIGHT_W = 9;
   localparam int MODE_W   = 3;
   localparam int MASK_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int CHANNELS   = 3;

   localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;
   localparam logic [MASK_W-1:0]   MASK_ALL    = 3'd7;

   // Latency from an accepted item to its result strobe.
   localparam int LATENCY = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_REPLACE = 3'd0,
      MODE_SUM     = 3'd1,
      MODE_SUB     = 3'd2,
      MODE_MULT    = 3'd3,
      MODE_AVG     = 3'd4,
      MODE_MIN     = 3'd5,
      MODE_MAX     = 3'd6,
      MODE_PASS    = 3'd7
   } blend_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLEND_MODE   = 2'd0,
      CSR_LAYER_WEIGHT = 2'd1,
      CSR_CHANNEL_MASK = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   // Per-channel controls that travel with an item.
   typedef struct packed {
      blend_mode_type        mode;
      logic [WEIGHT_W-1:0]   weight;
      logic                  take;
   } chan_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/layer_pixel_blend.sv */
// Top level of the layer pixel blend block: control registers, input stage,
// valid pipeline and three lpb_channel datapaths. Depends on lpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Blends one layer pixel onto one destination pixel per item. An item is
// taken whenever start is high; busy never rises, so a new item may enter on
// every clock. The result appears on the rsp_ ports with rsp_valid high for
// one cycle, after the input register and the four datapath stages that the
// two-stage multiply and the divide by 255 in multiply mode require. The
// receiver cannot stall the block and need not.
// Write the control registers only while no item is in flight; the csr port
// is always ready.

module layer_pixel_blend
   import lpb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [PIX_W-1:0]       req_src_red,
   input  wire logic [PIX_W-1:0]       req_src_green,
   input  wire logic [PIX_W-1:0]       req_src_blue,
   input  wire logic [PIX_W-1:0]       req_dst_red,
   input  wire logic [PIX_W-1:0]       req_dst_green,
   input  wire logic [PIX_W-1:0]       req_dst_blue,

   output logic                        rsp_valid,
   output logic      [PIX_W-1:0]       rsp_out_red,
   output logic      [PIX_W-1:0]       rsp_out_green,
   output logic      [PIX_W-1:0]       rsp_out_blue,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // control registers
   blend_mode_type        mode_ff;
   logic [WEIGHT_W-1:0]   weight_ff;
   logic [MASK_W-1:0]     mask_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_REPLACE;
         weight_ff <= WEIGHT_FULL;
         mask_ff   <= MASK_ALL;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLEND_MODE:   mode_ff   <= blend_mode_type'(csr_data[MODE_W-1:0]);
            CSR_LAYER_WEIGHT: weight_ff <= csr_data[WEIGHT_W-1:0];
            CSR_CHANNEL_MASK: mask_ff   <= csr_data[MASK_W-1:0];
            default:          ;
         endcase
      end
   end

   // valid bits travel alongside the datapath
   logic [LATENCY-1:0] valid_ff, valid_in;

   assign valid_in = {valid_ff[LATENCY-2:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[LATENCY-1];

   // input stage: hold the pixel and a snapshot of the controls
   logic [PIX_W-1:0]      src_ff [CHANNELS];
   logic [PIX_W-1:0]      dst_ff [CHANNELS];
   blend_mode_type        cmode_ff;
   logic [WEIGHT_W-1:0]   cweight_ff, cweight_in;
   logic [MASK_W-1:0]     cmask_ff;

   // saturate weights above full scale
   assign cweight_in = (weight_ff > WEIGHT_FULL) ? WEIGHT_FULL : weight_ff;

   always_ff @(posedge clock) begin
      src_ff[0]  <= req_src_red;
      src_ff[1]  <= req_src_green;
      src_ff[2]  <= req_src_blue;
      dst_ff[0]  <= req_dst_red;
      dst_ff[1]  <= req_dst_green;
      dst_ff[2]  <= req_dst_blue;
      cmode_ff   <= mode_ff;
      cweight_ff <= cweight_in;
      cmask_ff   <= mask_ff;
   end

   logic [PIX_W-1:0] result [CHANNELS];

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      chan_ctl_type ctl;

      assign ctl.mode   = cmode_ff;
      assign ctl.weight = cweight_ff;
      assign ctl.take   = cmask_ff[c];

      lpb_channel u_channel (
         .clock  (clock),
         .ctl    (ctl),
         .src    (src_ff[c]),
         .dst    (dst_ff[c]),
         .result (result[c])
      );
   end

   assign rsp_out_red   = result[0];
   assign rsp_out_green = result[1];
   assign rsp_out_blue  = result[2];

endmodule

`default_nettype wire

/* rtl/core/lpb_channel.sv */
// Four-stage blend datapath for one color channel.
// Depends on lpb_pkg for the mode codes and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module lpb_channel
   import lpb_pkg::*;
(
   input  wire logic               clock,
   input  wire chan_ctl_type       ctl,
   input  wire logic [PIX_W-1:0]   src,
   input  wire logic [PIX_W-1:0]   dst,
   output logic      [PIX_W-1:0]   result
);

   // stage 1: scaled layer value and src*dst product
   chan_ctl_type          ctl1_ff;
   logic [PIX_W-1:0]      s1_ff, dst1_ff;
   logic [2*PIX_W-1:0]    p1_ff;
   logic [WEIGHT_W-1:0]   wc1_ff;
   logic [16:0]           sw;

   assign sw = 17'(src) * 17'(ctl.weight);

   always_ff @(posedge clock) begin
      ctl1_ff <= ctl;
      s1_ff   <= sw[15:8];
      dst1_ff <= dst;
      p1_ff   <= 16'(src) * 16'(dst);
      wc1_ff  <= WEIGHT_FULL - ctl.weight;
   end

   // stage 2: multiply terms and the result of the simple modes
   chan_ctl_type          ctl2_ff;
   logic [PIX_W-1:0]      dst2_ff, alt2_ff, alt2_in;
   logic [16:0]           t12_ff;
   logic [23:0]           t22_ff;
   logic [PIX_W:0]        add1;

   assign add1 = 9'(s1_ff) + 9'(dst1_ff);

   always_comb begin
      case (ctl1_ff.mode)
         MODE_REPLACE: alt2_in = s1_ff;
         MODE_SUM:     alt2_in = add1[PIX_W] ? 8'd255 : add1[PIX_W-1:0];
         MODE_SUB:     alt2_in = (s1_ff > dst1_ff) ? (s1_ff - dst1_ff) : 8'd0;
         MODE_AVG:     alt2_in = add1[PIX_W:1];
         MODE_MIN:     alt2_in = (dst1_ff < s1_ff) ? dst1_ff : s1_ff;
         MODE_MAX:     alt2_in = (dst1_ff > s1_ff) ? dst1_ff : s1_ff;
         default:      alt2_in = dst1_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ctl2_ff <= ctl1_ff;
      dst2_ff <= dst1_ff;
      alt2_ff <= alt2_in;
      t12_ff  <= 17'(wc1_ff) * 17'(dst1_ff);
      t22_ff  <= 24'(p1_ff) * 24'(ctl1_ff.weight);
   end

   // stage 3: (256-w)*dst*255 + dst*src*w, then drop the factor of 256
   chan_ctl_type          ctl3_ff;
   logic [PIX_W-1:0]      dst3_ff, alt3_ff;
   logic [15:0]           y3_ff;
   logic [24:0]           sum;

   assign sum = {t12_ff, 8'd0} - 25'(t12_ff) + 25'(t22_ff);

   always_ff @(posedge clock) begin
      ctl3_ff <= ctl2_ff;
      dst3_ff <= dst2_ff;
      alt3_ff <= alt2_ff;
      y3_ff   <= sum[23:8];
   end

   // stage 4: divide by 255 with one correction step, final select
   logic [PIX_W-1:0] q0, q;
   logic [PIX_W:0]   rem;
   logic [PIX_W-1:0] result_in, result_ff;

   assign q0  = y3_ff[15:8];
   assign rem = 9'(y3_ff[7:0]) + 9'(q0);
   assign q   = q0 + 8'(rem >= 9'd255);

   always_comb begin
      if (ctl3_ff.mode == MODE_PASS) begin
         result_in = dst3_ff;
      end else if (!ctl3_ff.take) begin
         result_in = (ctl3_ff.mode == MODE_REPLACE) ? 8'd0 : dst3_ff;
      end else if (ctl3_ff.mode == MODE_MULT) begin
         result_in = q;
      end else begin
         result_in = alt3_ff;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for layer_pixel_blend: sends pixel items, writes the
// blend registers between phases and checks every rsp_ strobe against a local
// prediction. Depends on lpb_pkg and the layer_pixel_blend RTL.

module testbench
   import lpb_pkg::*;
;

   typedef logic [CHANNELS-1:0][PIX_W-1:0] rgb_type;   // [0] red, [1] green, [2] blue

   localparam int unsigned MULT_DIVISOR = 255 * 256;
   localparam int unsigned RANDOM_ITEMS = 600;
   localparam int unsigned STEADY_ITEMS = 150;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   rgb_type               req_src   = '0;
   rgb_type               req_dst   = '0;
   logic                  rsp_valid;
   logic [PIX_W-1:0]      rsp_out_red;
   logic [PIX_W-1:0]      rsp_out_green;
   logic [PIX_W-1:0]      rsp_out_blue;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_BLEND_MODE;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // Local copy of the control registers.
   blend_mode_type        cur_mode   = MODE_REPLACE;
   logic [WEIGHT_W-1:0]   cur_weight = WEIGHT_FULL;
   logic [MASK_W-1:0]     cur_mask   = MASK_ALL;

   rgb_type               expected_pixels [$];
   int unsigned           error_count  = 0;
   int unsigned           pixels_sent  = 0;
   int unsigned           pixels_seen  = 0;
   int unsigned           config_count = 0;
   logic                  steady       = 1'b0;

   layer_pixel_blend dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_src_red   (req_src[0]),
      .req_src_green (req_src[1]),
      .req_src_blue  (req_src[2]),
      .req_dst_red   (req_dst[0]),
      .req_dst_green (req_dst[1]),
      .req_dst_blue  (req_dst[2]),
      .rsp_valid     (rsp_valid),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [PIX_W-1:0] blend_channel_value(blend_mode_type mode,
         int unsigned w, int unsigned src, int unsigned dst);
      int unsigned scaled;
      int unsigned value;
      scaled = (src * w) >> 8;
      case (mode)
         MODE_REPLACE: value = scaled;
         MODE_SUM:     value = dst + scaled;
         MODE_SUB:     value = (scaled > dst) ? scaled - dst : 0;
         MODE_MULT:    value = ((WEIGHT_FULL - w) * dst * 255 + dst * src * w) / MULT_DIVISOR;
         MODE_AVG:     value = (dst + scaled) >> 1;
         MODE_MIN:     value = (dst < scaled) ? dst : scaled;
         MODE_MAX:     value = (dst > scaled) ? dst : scaled;
         default:      value = dst;
      endcase
      return (value > 255) ? 8'd255 : value[PIX_W-1:0];
   endfunction

   function automatic rgb_type blend_pixel(rgb_type src, rgb_type dst);
      rgb_type     result;
      int unsigned w;
      // weights above full saturate
      w = (cur_weight > WEIGHT_FULL) ? WEIGHT_FULL : cur_weight;
      for (int c = 0; c < CHANNELS; c++) begin
         if (cur_mode == MODE_PASS) begin
            result[c] = dst[c];
         end else if (cur_mask[c]) begin
            result[c] = blend_channel_value(cur_mode, w, src[c], dst[c]);
         end else begin
            result[c] = (cur_mode == MODE_REPLACE) ? '0 : dst[c];
         end
      end
      return result;
   endfunction

   function automatic rgb_type random_rgb();
      rgb_type px;
      for (int c = 0; c < CHANNELS; c++) begin
         case ($urandom_range(7))
            0:       px[c] = '0;
            1:       px[c] = '1;
            default: px[c] = PIX_W'($urandom_range(255));
         endcase
      end
      return px;
   endfunction

   // Check each result against the oldest expected pixel.
   always @(posedge clock) begin
      rgb_type got;
      rgb_type want;
      string names [CHANNELS];
      names = '{"red", "green", "blue"};
      if (!reset && rsp_valid === 1'b1) begin
         got = {rsp_out_blue, rsp_out_green, rsp_out_red};
         pixels_seen++;
         if (expected_pixels.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                     $time, got[0], got[1], got[2]);
         end else begin
            want = expected_pixels.pop_front();
            for (int c = 0; c < CHANNELS; c++) begin
               if (got[c] !== want[c]) begin
                  error_count++;
                  $display("%0t: out_%s mismatch: expected %0d, actual %0d",
                           $time, names[c], want[c], got[c]);
               end
            end
         end
      end
   end

   task automatic send_pixel(input rgb_type src, input rgb_type dst);
      if (!steady && $urandom_range(99) < 9) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start   <= 1'b1;
      req_src <= src;
      req_dst <= dst;
      do @(posedge clock); while (busy);
      expected_pixels.push_back(blend_pixel(src, dst));
      pixels_sent++;
   endtask

   // Drop start and hold until every expected pixel has come back.
   task automatic drain_pixels();
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BLEND_MODE:   cur_mode   = blend_mode_type'(data[MODE_W-1:0]);
         CSR_LAYER_WEIGHT: cur_weight = data[WEIGHT_W-1:0];
         CSR_CHANNEL_MASK: cur_mask   = data[MASK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_blend(input blend_mode_type mode, input logic [WEIGHT_W-1:0] weight,
         input logic [MASK_W-1:0] mask);
      drain_pixels();
      write_register(CSR_BLEND_MODE, CSR_DATA_W'(mode));
      write_register(CSR_LAYER_WEIGHT, weight);
      write_register(CSR_CHANNEL_MASK, CSR_DATA_W'(mask));
      // the spare index must change nothing
      if ($urandom_range(3) == 0) write_register(CSR_UNUSED, CSR_DATA_W'($urandom_range(511)));
      csr_valid <= 1'b0;
      config_count++;
   endtask

   task automatic test_reset_defaults();
      send_pixel('0, '1);
      send_pixel('1, '0);
      send_pixel({8'd17, 8'd128, 8'd254}, {8'd200, 8'd3, 8'd99});
   endtask

   task automatic test_each_mode();
      for (int m = 0; m <= int'(MODE_PASS); m++) begin
         program_blend(blend_mode_type'(m), WEIGHT_FULL, MASK_ALL);
         send_pixel('1, {8'd0, 8'd128, 8'd255});
         send_pixel({8'd200, 8'd10, 8'd128}, {8'd100, 8'd250, 8'd128});
      end
   endtask

   task automatic test_weight_limits();
      program_blend(MODE_MULT, '0, MASK_ALL);
      send_pixel('1, {8'd255, 8'd77, 8'd1});
      program_blend(MODE_SUM, '1, MASK_ALL);
      send_pixel({8'd255, 8'd128, 8'd1}, {8'd255, 8'd200, 8'd0});
      program_blend(MODE_MAX, 9'd257, 3'b101);
      send_pixel({8'd60, 8'd255, 8'd0}, {8'd61, 8'd0, 8'd255});
   endtask

   task automatic test_empty_mask();
      program_blend(MODE_SUM, 9'd128, '0);
      send_pixel('1, {8'd9, 8'd180, 8'd255});
      program_blend(MODE_REPLACE, WEIGHT_FULL, '0);
      send_pixel('1, '1);
   endtask

   task automatic test_random_blends();
      int unsigned     sent;
      int unsigned     batch;
      int unsigned     pause_at;
      blend_mode_type  mode;
      logic [WEIGHT_W-1:0] weight;
      logic [MASK_W-1:0]   mask;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode = ($urandom_range(15) == 0) ? MODE_PASS : blend_mode_type'($urandom_range(6));
         case ($urandom_range(7))
            0:       weight = '0;
            1:       weight = WEIGHT_FULL;
            2:       weight = WEIGHT_W'($urandom_range(257, 511));
            3:       weight = 9'd255;
            default: weight = WEIGHT_W'($urandom_range(1, 255));
         endcase
         mask = ($urandom_range(2) == 0) ? MASK_ALL : MASK_W'($urandom_range(7));
         program_blend(mode, weight, mask);
         // first batch runs back to back with no gaps
         steady   = (sent == 0);
         batch    = steady ? STEADY_ITEMS : $urandom_range(10, 60);
         pause_at = $urandom_range(1, batch - 1);
         for (int i = 0; i < batch; i++) begin
            if (i == pause_at && (config_count % 3) == 0) drain_pixels();
            send_pixel(random_rgb(), random_rgb());
         end
         steady = 1'b0;
         sent  += batch;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_each_mode();
      test_weight_limits();
      test_empty_mask();
      test_random_blends();
      drain_pixels();
      // catch any stray strobe after the last result
      repeat (LATENCY + 2) @(posedge clock);
      $display("Sent %0d pixels, checked %0d results over %0d register settings,",
               pixels_sent, pixels_seen, config_count);
      $display("covering all blend modes, weight extremes, partial and empty masks.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/lpb_pkg.sv
rtl/core/lpb_channel.sv
rtl/core/layer_pixel_blend.sv
tb/sv/testbench.sv
